/* hdl/pdsl_pkg.sv */
// Package for the PLL divider serial loader.
// Holds the item types, frame constants and the frame builder function.
// Has no dependencies.
package pdsl_pkg;

    localparam int unsigned REF_WIDTH      = 16;
    localparam int unsigned RATIO_WIDTH    = 16;
    localparam int unsigned PRESCALE_BITS  = 5;
    localparam int unsigned MAIN_BITS      = 11;
    localparam int unsigned FRAME_BITS     = 19;
    localparam int unsigned COUNT_WIDTH    = $clog2(FRAME_BITS + 1);

    localparam logic [REF_WIDTH-1:0] REF_RESET = 16'h8961;

    localparam logic MODE_REFERENCE = 1'b0;
    localparam logic MODE_DIVIDER   = 1'b1;

    localparam logic [COUNT_WIDTH-1:0] REF_FRAME_LEN = COUNT_WIDTH'(REF_WIDTH);
    localparam logic [COUNT_WIDTH-1:0] DIV_FRAME_LEN = COUNT_WIDTH'(FRAME_BITS);

    typedef struct packed {
        logic                   mode;
        logic [RATIO_WIDTH-1:0] divide_ratio;
    } t_req;

    typedef struct packed {
        logic data_bit;
        logic latch_pulse;
        logic last;
    } t_result;

    typedef struct packed {
        logic [FRAME_BITS-1:0]  word;
        logic [COUNT_WIDTH-1:0] nbits;
    } t_frame;

    // The frame is left-aligned so the first bit sent is always the MSB.
    function automatic t_frame build_frame(t_req req, logic [REF_WIDTH-1:0] ref_word);
        t_frame f;
        if (req.mode == MODE_REFERENCE) begin
            f.word  = {ref_word, {(FRAME_BITS - REF_WIDTH){1'b0}}};
            f.nbits = REF_FRAME_LEN;
        end else begin
            f.word  = {req.divide_ratio[RATIO_WIDTH-1 -: MAIN_BITS], 2'b00,
                       req.divide_ratio[PRESCALE_BITS-1:0], 1'b0};
            f.nbits = DIV_FRAME_LEN;
        end
        return f;
    endfunction

endpackage

/* hdl/pdsl_framer.sv */
// Input stage of the PLL divider serial loader.
// Registers one request as a ready-to-send frame; uses pdsl_pkg.
module pdsl_framer
    import pdsl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_req                 i_in,
    input  logic [REF_WIDTH-1:0] i_reference_word,
    output logic                 o_frame_valid,
    input  logic                 i_frame_ready,
    output t_frame               o_frame
);

    logic   r_valid;
    t_frame r_frame;
    logic   n_valid;

    assign o_in_ready    = !r_valid || i_frame_ready;
    assign o_frame_valid = r_valid;
    assign o_frame       = r_frame;

    always_comb begin
        n_valid = r_valid;
        if (o_in_ready) begin
            n_valid = i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_frame <= build_frame(i_in, i_reference_word);
        end
    end

endmodule

/* hdl/pdsl_shifter.sv */
// Serializer of the PLL divider serial loader.
// Shifts a frame out one bit per item and closes it with a latch item; uses pdsl_pkg.
module pdsl_shifter
    import pdsl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_frame_valid,
    output logic    o_frame_ready,
    input  t_frame  i_frame,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_out
);

    logic                   r_busy;
    logic [FRAME_BITS-1:0]  r_word;
    logic [COUNT_WIDTH-1:0] r_remain;
    logic                   r_out_valid;
    t_result                r_out;

    logic    slot_free;
    logic    emit;
    logic    load;
    t_result slot;

    assign slot_free     = !r_out_valid || i_out_ready;
    assign emit          = r_busy && slot_free;
    assign o_frame_ready = !r_busy || (emit && (r_remain == '0));
    assign load          = o_frame_ready && i_frame_valid;

    always_comb begin
        if (r_remain != '0) begin
            slot = '{data_bit: r_word[FRAME_BITS-1], latch_pulse: 1'b0, last: 1'b0};
        end else begin
            slot = '{data_bit: 1'b0, latch_pulse: 1'b1, last: 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
            end else if (emit && (r_remain == '0)) begin
                r_busy <= 1'b0;
            end
            if (slot_free) begin
                r_out_valid <= r_busy;
            end
        end
        if (load) begin
            r_word   <= i_frame.word;
            r_remain <= i_frame.nbits;
        end else if (emit && (r_remain != '0)) begin
            r_word   <= {r_word[FRAME_BITS-2:0], 1'b0};
            r_remain <= r_remain - 1'b1;
        end
        if (emit) begin
            r_out <= slot;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_latch_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.latch_pulse == o_out.last))
        else $error("Latch item and last flag disagree.");

    a_latch_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.latch_pulse) |-> !o_out.data_bit)
        else $error("Data bit set during the latch item.");

    a_remain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_remain <= DIV_FRAME_LEN))
        else $error("Bit count out of range.");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> r_busy)
        else $error("Frame loaded but serializer not busy.");

endmodule

/* hdl/pll_divider_serial_loader.sv */
// The first item of a request passes the framer register, the shifter word register and the output register.
// Throughput: one output item per cycle while i_out_ready is high; a reference request gives 17 items and a
// divider request 20, and the next request is taken while the current one shifts out.
// Reset clears all valid flags and loads the reference word with 0x8961.
// Top level of the PLL divider serial loader; uses pdsl_pkg, pdsl_framer, pdsl_shifter.
module pll_divider_serial_loader
    import pdsl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_req                 i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_result              o_out,
    input  logic                 i_cfg_wr_en,
    input  logic [REF_WIDTH-1:0] i_cfg_wr_data
);

    logic [REF_WIDTH-1:0] r_reference_word;
    logic                 frame_valid;
    logic                 frame_ready;
    t_frame               frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reference_word <= REF_RESET;
        end else if (i_cfg_wr_en) begin
            r_reference_word <= i_cfg_wr_data;
        end
    end

    pdsl_framer u_framer (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_in             (i_in),
        .i_reference_word (r_reference_word),
        .o_frame_valid    (frame_valid),
        .i_frame_ready    (frame_ready),
        .o_frame          (frame)
    );

    pdsl_shifter u_shifter (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame_valid (frame_valid),
        .o_frame_ready (frame_ready),
        .i_frame       (frame),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out         (o_out)
    );

endmodule
